// ----- hw/rtl/pcc_pkg.sv -----
// Shared types and constants of the convex polygon clipper.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int MAX_VERTS = 64;
    localparam int MAX_CLIP  = 16;
    localparam int VIDX_W    = $clog2(MAX_VERTS);
    localparam int VCNT_W    = $clog2(MAX_VERTS + 1);
    localparam int CIDX_W    = $clog2(MAX_CLIP);
    localparam int CCNT_W    = $clog2(MAX_CLIP + 1);

    localparam int CQ_DEPTH  = 4;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // Quotient bits resolved by the divider; larger quotients saturate.
    localparam int DIV_QBITS = 34;
    localparam int DIV_CNT_W = $clog2(DIV_QBITS + 1);

    localparam logic [1:0] FUNC_SUBJ = 2'd0;
    localparam logic [1:0] FUNC_CLIP = 2'd1;
    localparam logic [1:0] FUNC_RUN  = 2'd2;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_SUBJ,
        CMD_CLIP,
        CMD_RUN
    } cmd_t;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last_vertex;
        logic               empty_result;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef struct packed {
        cmd_t   cmd;
        point_t pt;
    } cmd_word_t;

    typedef struct packed {
        logic        start;
        logic [98:0] num;
        logic [65:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [34:0] quo;
    } div_rsp_t;

endpackage

// ----- hw/rtl/pcc_front.sv -----
// Front end: decodes incoming words into commands and queues them.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  pcc_pkg::in_word_t   item,
    input  logic                cmd_pop,
    output logic                cmd_valid,
    output pcc_pkg::cmd_word_t  cmd_word
);

    pcc_pkg::cmd_word_t              queue_reg [pcc_pkg::CQ_DEPTH];
    logic [pcc_pkg::CQ_PTR_W-1:0]    wptr_reg;
    logic [pcc_pkg::CQ_PTR_W-1:0]    rptr_reg;
    logic [pcc_pkg::CQ_CNT_W-1:0]    cnt_reg;
    pcc_pkg::cmd_t                   cmd_dec;
    logic                            wr_en;
    logic                            rd_en;

    always_comb
    begin
        unique case (item.func)
            pcc_pkg::FUNC_SUBJ: cmd_dec = pcc_pkg::CMD_SUBJ;
            pcc_pkg::FUNC_CLIP: cmd_dec = pcc_pkg::CMD_CLIP;
            pcc_pkg::FUNC_RUN:  cmd_dec = pcc_pkg::CMD_RUN;
            default:            cmd_dec = pcc_pkg::CMD_NOP;
        endcase
    end

    assign full      = (cnt_reg == pcc_pkg::CQ_CNT_W'(pcc_pkg::CQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_word  = queue_reg[rptr_reg];

    // Unused function codes are accepted and dropped here.
    assign wr_en = push && !full && (cmd_dec != pcc_pkg::CMD_NOP);
    assign rd_en = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wptr_reg] <= '{cmd: cmd_dec, pt: '{x: item.x_coord, y: item.y_coord}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/pcc_div.sv -----
// Restoring divider, one quotient bit per cycle, with saturation check.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pcc_pkg::div_req_t  req,
    output pcc_pkg::div_rsp_t  rsp
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t                           state_reg;
    logic [65:0]                       den_reg;
    logic [65:0]                       rem_reg;
    logic [pcc_pkg::DIV_QBITS-1:0]     bits_reg;
    logic [pcc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [34:0]                       quo_reg;
    logic                              done_reg;
    logic [66:0]                       rem2;
    logic                              ge;
    logic                              sat;

    assign rem2 = {rem_reg, bits_reg[pcc_pkg::DIV_QBITS-1]};
    assign ge   = (rem2 >= {1'b0, den_reg});
    assign sat  = ({1'b0, req.num} >= {req.den, 34'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            den_reg   <= '0;
            rem_reg   <= '0;
            bits_reg  <= '0;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        den_reg <= req.den;
                        if (sat)
                        begin
                            quo_reg  <= 35'(1) << pcc_pkg::DIV_QBITS;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= {1'b0, req.num[98:pcc_pkg::DIV_QBITS]};
                            bits_reg  <= req.num[pcc_pkg::DIV_QBITS-1:0];
                            cnt_reg   <= pcc_pkg::DIV_CNT_W'(pcc_pkg::DIV_QBITS);
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= ge ? 66'(rem2 - {1'b0, den_reg}) : rem2[65:0];
                    bits_reg <= {bits_reg[pcc_pkg::DIV_QBITS-2:0], ge};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == pcc_pkg::DIV_CNT_W'(1))
                    begin
                        quo_reg   <= {1'b0, bits_reg[pcc_pkg::DIV_QBITS-2:0], ge};
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hw/rtl/pcc_back.sv -----
// Back end: vertex stores, clip sequencer, shared multiplier, result emission.
// Depends on pcc_pkg and pcc_div.
`timescale 1ns / 1ps

module pcc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  pcc_pkg::cmd_word_t  cmd_word,
    output logic                cmd_pop,
    input  logic                oq_full,
    output logic                oq_push,
    output pcc_pkg::out_word_t  oq_word
);

    typedef enum logic [4:0] {
        B_IDLE, B_EA, B_EB, B_EC, B_VP, B_VQ, B_VD, B_MUL,
        B_XM0, B_XM1, B_XM2, B_XDIV, B_PUSHX, B_PUSHQ, B_NEXT, B_PEND,
        B_EMIT0, B_ERD, B_EWR
    } bstate_t;

    localparam int VI = pcc_pkg::VIDX_W;
    localparam int CI = pcc_pkg::CIDX_W;

    // Two vertex banks; one holds the subject polygon, the other collects a pass.
    pcc_pkg::point_t bank0_mem [pcc_pkg::MAX_VERTS];
    pcc_pkg::point_t bank1_mem [pcc_pkg::MAX_VERTS];
    pcc_pkg::point_t clip_mem  [pcc_pkg::MAX_CLIP];
    pcc_pkg::point_t bank0_rd_reg;
    pcc_pkg::point_t bank1_rd_reg;
    pcc_pkg::point_t clip_rd_reg;

    bstate_t                       state_reg;
    logic                          sel_reg;
    logic [pcc_pkg::VCNT_W-1:0]    subj_cnt_reg;
    logic [pcc_pkg::CCNT_W-1:0]    clip_cnt_reg;
    logic [pcc_pkg::VCNT_W-1:0]    ncnt_reg;
    logic                          ovf_reg;
    logic [CI-1:0]                 e_reg;
    logic [VI-1:0]                 i_reg;
    logic [VI-1:0]                 k_reg;
    logic [2:0]                    step_reg;
    logic                          coord_reg;
    pcc_pkg::point_t               a_reg;
    pcc_pkg::point_t               p_reg;
    pcc_pkg::point_t               q_reg;
    pcc_pkg::point_t               cross_reg;
    logic signed [32:0]            r2x_reg, r2y_reg, r1x_reg, r1y_reg;
    logic signed [32:0]            dpx_reg, dpy_reg, dqx_reg, dqy_reg;
    logic signed [67:0]            prod_reg;
    logic signed [67:0]            t0_reg, cp_reg, cq_reg;
    logic [65:0]                   nmag_reg, dmag_reg, lo_reg;
    logic                          nneg_reg, dneg_reg;

    logic signed [33:0]            mul_a, mul_b;
    logic [VI-1:0]                 j_idx;
    logic [CI-1:0]                 f_idx;
    logic [VI-1:0]                 sub_raddr;
    logic [CI-1:0]                 clip_raddr;
    pcc_pkg::point_t               sub_rd;
    logic                          bank_we;
    logic                          bank_wsel;
    logic [VI-1:0]                 bank_waddr;
    pcc_pkg::point_t               bank_wdata;
    logic                          clip_we;
    logic                          subj_room, clip_room, pass_room;
    logic                          pin, qin;
    logic signed [67:0]            den_w;
    logic signed [32:0]            r1c;
    logic [32:0]                   r1mag;
    logic signed [31:0]            pc;
    logic [34:0]                   qv;
    logic signed [36:0]            sv;
    logic signed [31:0]            vsat;
    pcc_pkg::div_req_t             dreq;
    pcc_pkg::div_rsp_t             drsp;
    logic                          emit_last;

    pcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign j_idx = (({1'b0, i_reg} + 1'b1) == subj_cnt_reg) ? '0 : VI'(i_reg + 1'b1);
    assign f_idx = (({1'b0, e_reg} + 1'b1) == clip_cnt_reg) ? '0 : CI'(e_reg + 1'b1);

    assign subj_room = (subj_cnt_reg < pcc_pkg::VCNT_W'(pcc_pkg::MAX_VERTS));
    assign clip_room = (clip_cnt_reg < pcc_pkg::CCNT_W'(pcc_pkg::MAX_CLIP));
    assign pass_room = (ncnt_reg < pcc_pkg::VCNT_W'(pcc_pkg::MAX_VERTS));

    assign pin = !cp_reg[67] && (cp_reg != '0);
    assign qin = !cq_reg[67] && (cq_reg != '0);

    assign sub_rd  = sel_reg ? bank1_rd_reg : bank0_rd_reg;
    assign cmd_pop = (state_reg == B_IDLE) && cmd_valid;

    always_comb
    begin
        unique case (state_reg)
            B_VQ:         sub_raddr = j_idx;
            B_ERD, B_EWR: sub_raddr = k_reg;
            default:      sub_raddr = i_reg;
        endcase
        clip_raddr = (state_reg == B_EB) ? f_idx : e_reg;
    end

    always_comb
    begin
        bank_we    = 1'b0;
        bank_wsel  = !sel_reg;
        bank_waddr = ncnt_reg[VI-1:0];
        bank_wdata = q_reg;
        clip_we    = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                bank_wsel  = sel_reg;
                bank_waddr = subj_cnt_reg[VI-1:0];
                bank_wdata = cmd_word.pt;
                bank_we    = cmd_pop && (cmd_word.cmd == pcc_pkg::CMD_SUBJ) && subj_room;
                clip_we    = cmd_pop && (cmd_word.cmd == pcc_pkg::CMD_CLIP) && clip_room;
            end
            B_PUSHX:
            begin
                bank_wdata = cross_reg;
                bank_we    = pass_room;
            end
            B_PUSHQ: bank_we = pass_room;
            default: bank_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bank_we && !bank_wsel)
        begin
            bank0_mem[bank_waddr] <= bank_wdata;
        end
        if (bank_we && bank_wsel)
        begin
            bank1_mem[bank_waddr] <= bank_wdata;
        end
        bank0_rd_reg <= bank0_mem[sub_raddr];
        bank1_rd_reg <= bank1_mem[sub_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (clip_we)
        begin
            clip_mem[clip_cnt_reg[CI-1:0]] <= cmd_word.pt;
        end
        clip_rd_reg <= clip_mem[clip_raddr];
    end

    // Crossing coordinate being worked on: x first, then y.
    assign r1c   = coord_reg ? r1y_reg : r1x_reg;
    assign pc    = coord_reg ? p_reg.y : p_reg.x;
    assign r1mag = r1c[32] ? 33'(-r1c) : r1c;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_MUL:
            begin
                case (step_reg)
                    3'd0: begin mul_a = 34'(r2y_reg); mul_b = 34'(dpx_reg); end
                    3'd1: begin mul_a = 34'(r2x_reg); mul_b = 34'(dpy_reg); end
                    3'd2: begin mul_a = 34'(r2y_reg); mul_b = 34'(dqx_reg); end
                    3'd3: begin mul_a = 34'(r2x_reg); mul_b = 34'(dqy_reg); end
                    3'd4: begin mul_a = 34'(r2x_reg); mul_b = 34'(r1y_reg); end
                    3'd5: begin mul_a = 34'(r1x_reg); mul_b = 34'(r2y_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            B_XM0:
            begin
                mul_a = $signed({1'b0, nmag_reg[32:0]});
                mul_b = $signed({1'b0, r1mag});
            end
            B_XM1:
            begin
                mul_a = $signed({1'b0, nmag_reg[65:33]});
                mul_b = $signed({1'b0, r1mag});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign den_w = t0_reg - prod_reg;

    assign dreq.start = (state_reg == B_XM2);
    assign dreq.num   = {33'b0, lo_reg} + {prod_reg[65:0], 33'b0};
    assign dreq.den   = dmag_reg;

    // A zero denominator leaves the start point unchanged.
    assign qv = (dmag_reg == '0) ? '0 : drsp.quo;
    assign sv = (nneg_reg ^ r1c[32] ^ dneg_reg)
              ? (37'(pc) - $signed({2'b0, qv}))
              : (37'(pc) + $signed({2'b0, qv}));

    always_comb
    begin
        if (sv > 37'sd2147483647)
        begin
            vsat = 32'sh7fffffff;
        end
        else if (sv < -37'sd2147483648)
        begin
            vsat = 32'sh80000000;
        end
        else
        begin
            vsat = sv[31:0];
        end
    end

    assign emit_last = (({1'b0, k_reg} + 1'b1) == subj_cnt_reg);

    always_comb
    begin
        oq_push = 1'b0;
        oq_word = '{out_x: sub_rd.x, out_y: sub_rd.y, last_vertex: emit_last,
                    empty_result: 1'b0, overflow: ovf_reg};
        if (state_reg == B_EMIT0)
        begin
            oq_word = '{out_x: '0, out_y: '0, last_vertex: 1'b1,
                        empty_result: 1'b1, overflow: ovf_reg};
            oq_push = (subj_cnt_reg == '0) && !oq_full;
        end
        else if (state_reg == B_EWR)
        begin
            oq_push = !oq_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            sel_reg      <= 1'b0;
            subj_cnt_reg <= '0;
            clip_cnt_reg <= '0;
            ncnt_reg     <= '0;
            ovf_reg      <= 1'b0;
            e_reg        <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            step_reg     <= '0;
            coord_reg    <= 1'b0;
            a_reg        <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            cross_reg    <= '0;
            r2x_reg      <= '0;
            r2y_reg      <= '0;
            r1x_reg      <= '0;
            r1y_reg      <= '0;
            dpx_reg      <= '0;
            dpy_reg      <= '0;
            dqx_reg      <= '0;
            dqy_reg      <= '0;
            prod_reg     <= '0;
            t0_reg       <= '0;
            cp_reg       <= '0;
            cq_reg       <= '0;
            nmag_reg     <= '0;
            dmag_reg     <= '0;
            lo_reg       <= '0;
            nneg_reg     <= 1'b0;
            dneg_reg     <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        case (cmd_word.cmd)
                            pcc_pkg::CMD_SUBJ:
                            begin
                                if (subj_room) subj_cnt_reg <= subj_cnt_reg + 1'b1;
                                else           ovf_reg <= 1'b1;
                            end
                            pcc_pkg::CMD_CLIP:
                            begin
                                if (clip_room) clip_cnt_reg <= clip_cnt_reg + 1'b1;
                                else           ovf_reg <= 1'b1;
                            end
                            pcc_pkg::CMD_RUN:
                            begin
                                e_reg     <= '0;
                                state_reg <= (clip_cnt_reg == '0) ? B_EMIT0 : B_EA;
                            end
                            default: state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_EA: state_reg <= B_EB;
                B_EB:
                begin
                    a_reg     <= clip_rd_reg;
                    state_reg <= B_EC;
                end
                B_EC:
                begin
                    r2x_reg   <= 33'(clip_rd_reg.x) - 33'(a_reg.x);
                    r2y_reg   <= 33'(clip_rd_reg.y) - 33'(a_reg.y);
                    ncnt_reg  <= '0;
                    i_reg     <= '0;
                    state_reg <= (subj_cnt_reg == '0) ? B_PEND : B_VP;
                end
                B_VP: state_reg <= B_VQ;
                B_VQ:
                begin
                    p_reg     <= sub_rd;
                    state_reg <= B_VD;
                end
                B_VD:
                begin
                    q_reg     <= sub_rd;
                    dpx_reg   <= 33'(p_reg.x) - 33'(a_reg.x);
                    dpy_reg   <= 33'(p_reg.y) - 33'(a_reg.y);
                    dqx_reg   <= 33'(sub_rd.x) - 33'(a_reg.x);
                    dqy_reg   <= 33'(sub_rd.y) - 33'(a_reg.y);
                    r1x_reg   <= 33'(sub_rd.x) - 33'(p_reg.x);
                    r1y_reg   <= 33'(sub_rd.y) - 33'(p_reg.y);
                    step_reg  <= '0;
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        3'd1, 3'd3, 3'd5: t0_reg <= prod_reg;
                        3'd2: cp_reg <= t0_reg - prod_reg;
                        3'd4: cq_reg <= t0_reg - prod_reg;
                        3'd6:
                        begin
                            nmag_reg  <= cp_reg[67] ? 66'(-cp_reg) : cp_reg[65:0];
                            nneg_reg  <= cp_reg[67];
                            dmag_reg  <= den_w[67] ? 66'(-den_w) : den_w[65:0];
                            dneg_reg  <= den_w[67];
                            coord_reg <= 1'b0;
                            if (pin != qin)   state_reg <= B_XM0;
                            else if (qin)     state_reg <= B_PUSHQ;
                            else              state_reg <= B_NEXT;
                        end
                        default: t0_reg <= t0_reg;
                    endcase
                end
                B_XM0: state_reg <= B_XM1;
                B_XM1:
                begin
                    lo_reg    <= prod_reg[65:0];
                    state_reg <= B_XM2;
                end
                B_XM2: state_reg <= B_XDIV;
                B_XDIV:
                begin
                    if (drsp.done)
                    begin
                        if (!coord_reg)
                        begin
                            cross_reg.x <= vsat;
                            coord_reg   <= 1'b1;
                            state_reg   <= B_XM0;
                        end
                        else
                        begin
                            cross_reg.y <= vsat;
                            state_reg   <= B_PUSHX;
                        end
                    end
                end
                B_PUSHX:
                begin
                    if (pass_room) ncnt_reg <= ncnt_reg + 1'b1;
                    else           ovf_reg <= 1'b1;
                    state_reg <= qin ? B_PUSHQ : B_NEXT;
                end
                B_PUSHQ:
                begin
                    if (pass_room) ncnt_reg <= ncnt_reg + 1'b1;
                    else           ovf_reg <= 1'b1;
                    state_reg <= B_NEXT;
                end
                B_NEXT:
                begin
                    if (({1'b0, i_reg} + 1'b1) == subj_cnt_reg)
                    begin
                        state_reg <= B_PEND;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= B_VP;
                    end
                end
                B_PEND:
                begin
                    subj_cnt_reg <= ncnt_reg;
                    sel_reg      <= !sel_reg;
                    if (({1'b0, e_reg} + 1'b1) == clip_cnt_reg)
                    begin
                        state_reg <= B_EMIT0;
                    end
                    else
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= B_EA;
                    end
                end
                B_EMIT0:
                begin
                    k_reg <= '0;
                    if (subj_cnt_reg != '0)
                    begin
                        state_reg <= B_ERD;
                    end
                    else if (!oq_full)
                    begin
                        clip_cnt_reg <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= B_IDLE;
                    end
                end
                B_ERD: state_reg <= B_EWR;
                B_EWR:
                begin
                    if (!oq_full)
                    begin
                        if (emit_last)
                        begin
                            subj_cnt_reg <= '0;
                            clip_cnt_reg <= '0;
                            ovf_reg      <= 1'b0;
                            state_reg    <= B_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= B_ERD;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_subj_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        subj_cnt_reg <= pcc_pkg::VCNT_W'(pcc_pkg::MAX_VERTS))
        else $error("subject count above capacity");

    a_clip_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clip_cnt_reg <= pcc_pkg::CCNT_W'(pcc_pkg::MAX_CLIP))
        else $error("clip count above capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result pushed into a full queue");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == B_XDIV))
        else $error("divider finished outside its wait state");

endmodule

// ----- hw/rtl/pcc_outq.sv -----
// Result queue that decouples the back end from the result port.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                oq_push,
    input  pcc_pkg::out_word_t  oq_word,
    output logic                oq_full,
    input  logic                pop,
    output logic                empty,
    output pcc_pkg::out_word_t  result
);

    pcc_pkg::out_word_t              queue_reg [pcc_pkg::OQ_DEPTH];
    logic [pcc_pkg::OQ_PTR_W-1:0]    wptr_reg;
    logic [pcc_pkg::OQ_PTR_W-1:0]    rptr_reg;
    logic [pcc_pkg::OQ_CNT_W-1:0]    cnt_reg;
    logic                            wr_en;
    logic                            rd_en;

    assign oq_full = (cnt_reg == pcc_pkg::OQ_CNT_W'(pcc_pkg::OQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign result  = queue_reg[rptr_reg];
    assign wr_en   = oq_push && !oq_full;
    assign rd_en   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wptr_reg] <= oq_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/polygon_clip_convex.sv -----
// Top level of the convex polygon clipper.
// Depends on pcc_pkg, pcc_front, pcc_back (with pcc_div) and pcc_outq.
`timescale 1ns / 1ps

// Usage: the input channel is a queue write port (push, full, item). Each word
// is a subject-vertex load, a clip-vertex load or a run command; unused codes
// are taken and dropped. Words land in a four-entry command queue, so a few
// loads are taken back to back even while a run is busy.
// A load is executed once it reaches the head of the queue and the back end is
// idle. A run clips the subject polygon against every clip edge in turn: per
// edge a setup that reads the edge's two end points, then per subject vertex
// two store reads and seven steps of the shared 34x34 multiplier, and for each
// edge crossing a wait on the bit-serial divider, which resolves 34 quotient
// bits for x and again for y. Each result word is emitted through the registered
// read of the vertex store.
// The result channel is a queue read port (empty, pop, result): the oldest
// word shows while empty is low. When the receiver stalls, the two-entry result
// queue fills and the back end waits; the command queue keeps taking words
// until it is full as well. A run clears both vertex counts and the overflow flag.
// Reset empties both queues and clears the vertex counts and overflow flag; the
// store contents need no clearing, since only counted entries are ever read.

module polygon_clip_convex (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  pcc_pkg::in_word_t   item,
    output logic                empty,
    input  logic                pop,
    output pcc_pkg::out_word_t  result
);

    logic                 cmd_valid;
    logic                 cmd_pop;
    pcc_pkg::cmd_word_t   cmd_word;
    logic                 oq_full;
    logic                 oq_push;
    pcc_pkg::out_word_t   oq_word;

    // Front end: decodes and queues incoming words.
    pcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word)
    );

    // Back end: stores the polygons and carries out the clipping passes.
    pcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_pop   (cmd_pop),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_word   (oq_word)
    );

    // Result queue: holds finished words until the receiver pops them.
    pcc_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .oq_push (oq_push),
        .oq_word (oq_word),
        .oq_full (oq_full),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the convex polygon clipper polygon_clip_convex.
// Depends on pcc_pkg for the word types and function codes. A built-in clip
// predictor computes the expected vertices, and each popped word is checked.
`timescale 1ns / 1ps

module tb;

    import pcc_pkg::*;

    // Code 3 is not used by the block; it must be taken and dropped.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint UNIT = 64'sd65536;
    localparam int PERIOD = 12;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    polygon_clip_convex dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Predictor state: a copy of the vertex stores, counts and overflow flag.
    longint    subj_x [MAX_VERTS];
    longint    subj_y [MAX_VERTS];
    longint    clip_x [MAX_CLIP];
    longint    clip_y [MAX_CLIP];
    int        subj_n;
    int        clip_n;
    bit        ovf;
    out_word_t vertex_q [$];

    int  fail_count;
    int  burst_left;
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // A point is inside edge a->b only when it lies strictly to the right.
    function automatic bit is_inside(input longint px, input longint py, input longint ax,
                                     input longint ay, input longint bx, input longint by);
        logic signed [127:0] c;
        c = 128'(by - ay) * 128'(px - ax) - 128'(bx - ax) * 128'(py - ay);
        return c > 0;
    endfunction

    // One crossing coordinate: p + num*r1/den, truncated, quotient capped at 2^34.
    function automatic longint cross_coord(input longint p, input longint r1,
                                           input logic signed [127:0] num,
                                           input logic signed [127:0] den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] ar;
        logic [127:0] q;
        longint       v;
        if (den == 0)
        begin
            return p;
        end
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        ar = (r1 < 0) ? 128'(-r1) : 128'(r1);
        q = (an * ar) / ad;
        if (q > (128'd1 << 34))
        begin
            q = 128'd1 << 34;
        end
        if ((num < 0) ^ (r1 < 0) ^ (den < 0))
        begin
            v = p - longint'(q);
        end
        else
        begin
            v = p + longint'(q);
        end
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return v;
    endfunction

    // Clip the subject polygon against one directed edge a->b.
    function automatic void clip_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint              nx [MAX_VERTS];
        longint              ny [MAX_VERTS];
        int                  cnt;
        int                  j;
        longint              px, py, qx, qy;
        bit                  pin, qin;
        logic signed [127:0] num;
        logic signed [127:0] den;
        cnt = 0;
        for (int i = 0; i < subj_n; i++)
        begin
            j = (i + 1 == subj_n) ? 0 : i + 1;
            px = subj_x[i];
            py = subj_y[i];
            qx = subj_x[j];
            qy = subj_y[j];
            pin = is_inside(px, py, ax, ay, bx, by);
            qin = is_inside(qx, qy, ax, ay, bx, by);
            if (pin != qin)
            begin
                num = 128'(px - ax) * 128'(by - ay) - 128'(bx - ax) * 128'(py - ay);
                den = 128'(bx - ax) * 128'(qy - py) - 128'(qx - px) * 128'(by - ay);
                if (cnt < MAX_VERTS)
                begin
                    nx[cnt] = cross_coord(px, qx - px, num, den);
                    ny[cnt] = cross_coord(py, qy - py, num, den);
                    cnt++;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            if (qin)
            begin
                if (cnt < MAX_VERTS)
                begin
                    nx[cnt] = qx;
                    ny[cnt] = qy;
                    cnt++;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
        end
        for (int i = 0; i < cnt; i++)
        begin
            subj_x[i] = nx[i];
            subj_y[i] = ny[i];
        end
        subj_n = cnt;
    endfunction

    // Apply one accepted word to the predictor and queue the vertices it yields.
    function automatic void predict_clip(input in_word_t w);
        out_word_t o;
        int        f;
        case (w.func)
            FUNC_SUBJ:
            begin
                if (subj_n < MAX_VERTS)
                begin
                    subj_x[subj_n] = longint'(w.x_coord);
                    subj_y[subj_n] = longint'(w.y_coord);
                    subj_n++;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            FUNC_CLIP:
            begin
                if (clip_n < MAX_CLIP)
                begin
                    clip_x[clip_n] = longint'(w.x_coord);
                    clip_y[clip_n] = longint'(w.y_coord);
                    clip_n++;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            FUNC_RUN:
            begin
                for (int e = 0; e < clip_n; e++)
                begin
                    f = (e + 1 == clip_n) ? 0 : e + 1;
                    clip_edge(clip_x[e], clip_y[e], clip_x[f], clip_y[f]);
                end
                if (subj_n == 0)
                begin
                    o = '0;
                    o.last_vertex = 1'b1;
                    o.empty_result = 1'b1;
                    o.overflow = ovf;
                    vertex_q.push_back(o);
                end
                else
                begin
                    for (int k = 0; k < subj_n; k++)
                    begin
                        o.out_x = 32'(subj_x[k]);
                        o.out_y = 32'(subj_y[k]);
                        o.last_vertex = (k + 1 == subj_n);
                        o.empty_result = 1'b0;
                        o.overflow = ovf;
                        vertex_q.push_back(o);
                    end
                end
                subj_n = 0;
                clip_n = 0;
                ovf = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one word in the current burst; gaps fall between bursts.
    task automatic send_word(input logic [1:0] func, input longint x, input longint y);
        in_word_t w;
        int       gap;
        w.func = func;
        w.x_coord = 32'(x);
        w.y_coord = 32'(y);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= w;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_clip(w);
    endtask

    // Stop offering and wait until every expected vertex has been popped.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        wait (vertex_q.size() == 0);
    endtask

    // Receiver: stalls follow a rotating pattern that is re-drawn at random,
    // with a long hold-off whenever the pressure test asks for one.
    initial
    begin
        logic [7:0] pat;
        int         ph;
        pop = 1'b0;
        pat = 8'hff;
        ph = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (600) @(negedge clk);
            end
            if (ph % 64 == 0)
            begin
                pat = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
                if (pat == 8'h00)
                begin
                    pat = 8'h01;
                end
            end
            pop <= pat[ph % 8];
            ph++;
        end
    end

    // Result checker: each popped word against the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && pop && !empty)
        begin
            if (vertex_q.size() == 0)
            begin
                report($sformatf("unexpected word x=%h y=%h", result.out_x, result.out_y));
            end
            else
            begin
                e = vertex_q.pop_front();
                if (result.out_x !== e.out_x)
                    report($sformatf("out_x %h, want %h", result.out_x, e.out_x));
                if (result.out_y !== e.out_y)
                    report($sformatf("out_y %h, want %h", result.out_y, e.out_y));
                if (result.last_vertex !== e.last_vertex)
                    report($sformatf("last_vertex %b, want %b", result.last_vertex,
                                     e.last_vertex));
                if (result.empty_result !== e.empty_result)
                    report($sformatf("empty_result %b, want %b", result.empty_result,
                                     e.empty_result));
                if (result.overflow !== e.overflow)
                    report($sformatf("overflow %b, want %b", result.overflow, e.overflow));
            end
        end
    end

    function automatic longint rand_coord(input bit wide);
        if (wide)
        begin
            return longint'($signed(32'($urandom)));
        end
        return longint'($signed(32'($urandom_range(0, 32'h1f_ffff)))) - 64'sd1048576;
    endfunction

    // Clockwise rectangle, so its interior lies right of every edge.
    task automatic send_rect_clip(input longint x0, input longint y0,
                                  input longint x1, input longint y1);
        send_word(FUNC_CLIP, x0, y0);
        send_word(FUNC_CLIP, x0, y1);
        send_word(FUNC_CLIP, x1, y1);
        send_word(FUNC_CLIP, x1, y0);
    endtask

    task automatic test_directed();
        // Overlapping squares: crossings on two sides.
        send_word(FUNC_SUBJ, 0, 0);
        send_word(FUNC_SUBJ, 0, 4 * UNIT);
        send_word(FUNC_SUBJ, 4 * UNIT, 4 * UNIT);
        send_word(FUNC_SUBJ, 4 * UNIT, 0);
        send_rect_clip(2 * UNIT, 2 * UNIT, 6 * UNIT + 3, 6 * UNIT + 7);
        send_word(FUNC_RUN, 5, -5);
        // Extreme coordinates with no clip vertices pass through unchanged.
        send_word(FUNC_SUBJ, 64'sd2147483647, -64'sd2147483648);
        send_word(FUNC_SUBJ, -64'sd2147483648, 64'sd2147483647);
        send_word(FUNC_UNUSED, -1, -1);
        send_word(FUNC_RUN, 0, 0);
        // A single clip vertex makes a degenerate edge with nothing inside.
        send_word(FUNC_SUBJ, UNIT, UNIT);
        send_word(FUNC_CLIP, 0, 0);
        send_word(FUNC_RUN, 0, 0);
        // A run with nothing loaded gives the empty word.
        send_word(FUNC_RUN, 0, 0);
        // Extreme clip edges against extreme subject points force saturation.
        send_word(FUNC_SUBJ, -64'sd2147483648, -64'sd2147483648);
        send_word(FUNC_SUBJ, 64'sd2147483647, 64'sd2147483647);
        send_word(FUNC_SUBJ, 64'sd2147483647, -64'sd2147483648);
        send_word(FUNC_CLIP, -64'sd2147483648, 64'sd2147483647);
        send_word(FUNC_CLIP, 64'sd2147483647, -64'sd2147483647);
        send_word(FUNC_CLIP, 1, 1);
        send_word(FUNC_RUN, 0, 0);
        wait_drained();
    endtask

    // Full stores drop the extra vertex and raise overflow on every word.
    task automatic test_store_overflow();
        for (int i = 0; i < MAX_VERTS + 1; i++)
        begin
            send_word(FUNC_SUBJ, i * UNIT, (i % 2) * UNIT);
        end
        send_word(FUNC_RUN, 0, 0);
        send_word(FUNC_SUBJ, 0, 0);
        send_word(FUNC_SUBJ, 0, UNIT);
        send_word(FUNC_SUBJ, UNIT, 0);
        for (int i = 0; i < MAX_CLIP + 1; i++)
        begin
            send_word(FUNC_CLIP, -10 * UNIT + i, -10 * UNIT);
        end
        send_word(FUNC_RUN, 0, 0);
        wait_drained();
    endtask

    // 63 points inside a triangle and one outside: the cut edge adds two
    // crossings for one dropped point, so the pass grows past capacity.
    task automatic test_growth_overflow();
        longint m;
        m = 1000 * UNIT;
        for (int i = 0; i < MAX_VERTS - 1; i++)
        begin
            send_word(FUNC_SUBJ, -m / 2 + i * UNIT, -m / 2 + (i % 3) * UNIT);
        end
        send_word(FUNC_SUBJ, m, m);
        send_word(FUNC_CLIP, -m, -m);
        send_word(FUNC_CLIP, -m, m);
        send_word(FUNC_CLIP, m, -m);
        send_word(FUNC_RUN, 0, 0);
        wait_drained();
    endtask

    // The receiver holds off while runs and loads keep coming, so the result
    // and command queues both fill and full must stall the sender.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                send_word(FUNC_SUBJ, rand_coord(0), rand_coord(0));
            end
            send_word(FUNC_RUN, 0, 0);
        end
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int     sent;
        int     nv;
        int     nc;
        bit     wide;
        longint cx, cy, hw, hh;
        sent = 0;
        while (sent < n_items)
        begin
            wide = ($urandom_range(0, 3) == 0);
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            for (int i = 0; i < nv; i++)
            begin
                send_word(FUNC_SUBJ, rand_coord(wide), rand_coord(wide));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                cx = rand_coord(0);
                cy = rand_coord(0);
                hw = $urandom_range(1, 32'h10_0000);
                hh = $urandom_range(1, 32'h10_0000);
                send_rect_clip(cx - hw, cy - hh, cx + hw, cy + hh);
                nc = 4;
            end
            else
            begin
                nc = $urandom_range(0, 5);
                for (int i = 0; i < nc; i++)
                begin
                    send_word(FUNC_CLIP, rand_coord(wide), rand_coord(wide));
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_word(FUNC_UNUSED, rand_coord(1), rand_coord(1));
            end
            send_word(FUNC_RUN, rand_coord(1), rand_coord(1));
            sent += nv + nc + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        subj_n = 0;
        clip_n = 0;
        ovf = 1'b0;
        fail_count = 0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_store_overflow();
        test_growth_overflow();
        test_backpressure();
        test_random(110);

        wait_drained();
        repeat (300) @(posedge clk);
        if (vertex_q.size() != 0)
        begin
            report($sformatf("%0d vertices never arrived", vertex_q.size()));
        end
        if (fail_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
